// File: rtl/core/byte_ring_buffer_top_macros.svh
// assertion macros for the byte ring buffer checker
`ifndef BYTE_RING_BUFFER_TOP_MACROS_SVH
`define BYTE_RING_BUFFER_TOP_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define BRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define BRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/brb_pkg.sv
`timescale 1ns / 1ps

package brb_pkg;

    localparam int CNT_W  = 12;
    localparam int BYTE_W = 8;
    localparam int ACT_W  = 3;

    localparam logic [ACT_W-1:0] ACT_WRITE   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_READ    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ADV_RD  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ADV_WR  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd5;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] data_byte;
        logic [CNT_W-1:0]  count;
    } brb_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_data;
        logic              last;
        logic              accepted;
        logic [CNT_W-1:0]  readable;
        logic [CNT_W-1:0]  writable;
    } brb_out_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_BURST = 2'b10
    } brb_state_t;

endpackage

// File: rtl/core/byte_ring_buffer_top.sv
`timescale 1ns / 1ps

// Byte FIFO over a DEPTH-entry store that keeps one slot empty. Write, pointer
// advance, pointer clear, unused codes and empty read or peek take one beat in
// and load one result beat into the output register at the same edge, so with
// the result side ready one such item is taken every cycle. A read or peek of
// n bytes (n limited by MAX_BURST and the fill level) streams n beats at one
// per cycle while the result side is ready, through the store's registered
// read port: the burst state is entered, each byte is read into the read
// register and then loaded into the output register. No new input beat is
// taken until the final byte is loaded and the state returns to idle. An input
// beat is only taken while the output register is empty or drains in the same
// cycle. Every result beat carries the readable and writable counts after the
// action. The store has one write and one read port and needs no clearing
// after reset.
module byte_ring_buffer_top
    import brb_pkg::*;
#(
    parameter int DEPTH     = 4096,
    parameter int MAX_BURST = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  brb_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output brb_out_t m_data
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int LVL_W   = (PTR_W > CNT_W) ? PTR_W : CNT_W;
    localparam int BURST_W = $clog2(MAX_BURST + 1);

    logic [BYTE_W-1:0] mem [DEPTH];

    brb_state_t         state_reg, state_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   issue_addr_reg, issue_addr_next;
    logic [BURST_W-1:0] issue_left_reg, issue_left_next;
    logic               pend_reg, pend_next;
    logic               pend_last_reg;
    logic [BYTE_W-1:0]  rd_data_reg;
    logic [CNT_W-1:0]   burst_rd_reg, burst_wr_reg;
    logic               m_valid_reg, m_valid_next;
    brb_out_t           m_data_reg, m_data_next;

    logic               out_free;
    logic               take;
    logic               mem_we;
    logic               mem_re;
    logic [PTR_W-1:0]   level;
    logic [PTR_W-1:0]   level_next;
    logic [LVL_W-1:0]   level_ext;
    logic [LVL_W-1:0]   count_ext;
    logic [BURST_W-1:0] want;
    logic [BURST_W-1:0] n_beats;
    logic               is_burst;
    logic               full;

    function automatic logic [CNT_W-1:0] to_field(input logic [PTR_W-1:0] v);
        logic [LVL_W-1:0] t;
        t = LVL_W'(v);
        return t[CNT_W-1:0];
    endfunction

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign take      = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign level     = wptr_reg - rptr_reg;
    assign level_ext = LVL_W'(level);
    assign count_ext = LVL_W'(s_data.count);
    assign full      = (level == {PTR_W{1'b1}});

    assign want      = (s_data.count < CNT_W'(MAX_BURST)) ?
                       s_data.count[BURST_W-1:0] : BURST_W'(MAX_BURST);
    assign n_beats   = (LVL_W'(want) <= level_ext) ? want : level_ext[BURST_W-1:0];
    assign is_burst  = (s_data.action == ACT_READ || s_data.action == ACT_PEEK) &&
                       (n_beats != '0);

    assign mem_we    = take && (s_data.action == ACT_WRITE) && !full;
    assign mem_re    = (state_reg == ST_BURST) && (issue_left_reg != '0) &&
                       (!pend_reg || out_free);

    always_comb begin
        rptr_next = rptr_reg;
        wptr_next = wptr_reg;
        if (take) begin
            case (s_data.action)
                ACT_WRITE: begin
                    if (!full) begin
                        wptr_next = wptr_reg + PTR_W'(1);
                    end
                end
                ACT_READ: begin
                    rptr_next = rptr_reg + PTR_W'(n_beats);
                end
                ACT_ADV_RD: begin
                    rptr_next = rptr_reg + count_ext[PTR_W-1:0];
                end
                ACT_ADV_WR: begin
                    wptr_next = wptr_reg + count_ext[PTR_W-1:0];
                end
                ACT_CLEAR: begin
                    rptr_next = '0;
                    wptr_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign level_next = wptr_next - rptr_next;

    always_comb begin
        state_next      = state_reg;
        issue_addr_next = issue_addr_reg;
        issue_left_next = issue_left_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take && is_burst) begin
                    state_next      = ST_BURST;
                    issue_addr_next = rptr_reg;
                    issue_left_next = n_beats;
                end
            end
            ST_BURST: begin
                if (mem_re) begin
                    issue_addr_next = issue_addr_reg + PTR_W'(1);
                    issue_left_next = issue_left_reg - BURST_W'(1);
                end
                if (issue_left_reg == '0 && !pend_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        pend_next = pend_reg;
        if (mem_re) begin
            pend_next = 1'b1;
        end else if (pend_reg && out_free) begin
            pend_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (pend_reg && out_free) begin
            m_valid_next         = 1'b1;
            m_data_next.out_byte = rd_data_reg;
            m_data_next.has_data = 1'b1;
            m_data_next.last     = pend_last_reg;
            m_data_next.accepted = 1'b0;
            m_data_next.readable = burst_rd_reg;
            m_data_next.writable = burst_wr_reg;
        end else if (take && !is_burst) begin
            m_valid_next         = 1'b1;
            m_data_next.out_byte = '0;
            m_data_next.has_data = 1'b0;
            m_data_next.last     = 1'b1;
            m_data_next.accepted = mem_we;
            m_data_next.readable = to_field(level_next);
            m_data_next.writable = to_field(~level_next);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // byte store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wptr_reg] <= s_data.data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg   <= mem[issue_addr_reg];
            pend_last_reg <= (issue_left_reg == BURST_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            burst_rd_reg <= to_field(level_next);
            burst_wr_reg <= to_field(~level_next);
        end
        m_data_reg      <= m_data_next;
        issue_addr_reg  <= issue_addr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rptr_reg       <= '0;
            wptr_reg       <= '0;
            issue_left_reg <= '0;
            pend_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rptr_reg       <= rptr_next;
            wptr_reg       <= wptr_next;
            issue_left_reg <= issue_left_next;
            pend_reg       <= pend_next;
            m_valid_reg    <= m_valid_next;
        end
    end

endmodule

// File: rtl/core/brb_checker.sv
`timescale 1ns / 1ps

`include "byte_ring_buffer_top_macros.svh"

module brb_checker
    import brb_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input brb_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input brb_out_t m_data
);

    // stalled result beat holds
    `BRB_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")

    // a beat without a byte always closes its item
    `BRB_ASSERT_NOW(a_empty_last, m_valid && !m_data.has_data, m_data.last, "empty result not marked last")

    // a stored write reports no byte
    `BRB_ASSERT_NOW(a_acc_status, m_valid && m_data.accepted, !m_data.has_data && m_data.last, "accepted write beat carries a byte")

    // input beat only taken when the result slot frees
    `BRB_ASSERT_NOW(a_in_slot, s_valid && s_ready, !m_valid || m_ready, "input beat taken with result slot blocked")

endmodule

bind byte_ring_buffer_top brb_checker u_brb_checker (.*);
